// ----- rtl/bfds_pkg.sv -----
// Shared constants and types for the descending word sorter.
`default_nettype none
package bfds_pkg;

	localparam int CAPACITY = 256;
	localparam int WORD_W   = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = $clog2(CAPACITY);

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_ADD   = 2'd1;
	localparam logic [1:0] FUNC_PULL  = 2'd2;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              exhausted;
		logic              dropped;
	} bfds_res_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} bfds_ram_req_t;

endpackage
`default_nettype wire

// ----- rtl/bfds_ram.sv -----
// Simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none
module bfds_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/bfds_ctrl.sv -----
// Item sequencer: list state and the read-compare-shift insertion walk.
`default_nettype none
module bfds_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [1:0]              func,
	input  wire logic [63:0]             value,
	input  wire logic                    room,
	output logic                         res_valid,
	output bfds_pkg::bfds_res_t          res,
	output bfds_pkg::bfds_ram_req_t      ram_req,
	input  wire logic [bfds_pkg::WORD_W-1:0] ram_rdata
);
	import bfds_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SHIFT = 4'b0010,
		ST_WRITE = 4'b0100,
		ST_PULL  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] k_q;
	logic [WORD_W-1:0] w_q;
	logic              force_q;
	logic              lo_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rp_q;
	logic [WORD_W-1:0] pref_q;
	logic              pinned_q;

	logic              acc;
	logic              pin_hit;
	logic              full;
	logic              lo_new;
	logic [ADDR_W-1:0] cnt_a;
	logic              has_word;
	logic [ADDR_W-1:0] k_dec;
	logic              shift;
	logic              more;

	assign in_ready = (state_q == ST_IDLE) && room;
	assign acc      = in_valid && in_ready;
	assign pin_hit  = (pref_q != '0) && !pinned_q && (value == pref_q);
	assign full     = count_q >= CAP_CNT;
	assign lo_new   = pin_hit ? 1'b0 : pinned_q;
	assign cnt_a    = count_q[ADDR_W-1:0];
	assign has_word = rp_q < count_q;
	assign k_dec    = k_q - ADDR_W'(1);
	// a pinned word pushes every entry up; otherwise stop at the first entry >= word
	assign shift    = force_q || (w_q > ram_rdata);
	assign more     = k_dec > ADDR_W'(lo_q);

	always_comb begin
		ram_req   = '0;
		res_valid = 1'b0;
		res       = '0;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (func)
						FUNC_START: begin
							res_valid = 1'b1;
						end
						FUNC_ADD: begin
							if (full) begin
								res_valid   = 1'b1;
								res.dropped = 1'b1;
							end else if (cnt_a != ADDR_W'(lo_new)) begin
								ram_req.re    = 1'b1;
								ram_req.raddr = cnt_a - ADDR_W'(1);
							end
						end
						FUNC_PULL: begin
							if (!has_word) begin
								res_valid     = 1'b1;
								res.exhausted = 1'b1;
							end else begin
								ram_req.re    = 1'b1;
								ram_req.raddr = rp_q[ADDR_W-1:0];
							end
						end
						default: begin
							res_valid = 1'b1;
						end
					endcase
				end
			end
			ST_SHIFT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = k_q;
				if (shift) begin
					ram_req.wdata = ram_rdata;
					if (more) begin
						ram_req.re    = 1'b1;
						ram_req.raddr = k_dec - ADDR_W'(1);
					end
				end else begin
					ram_req.wdata = w_q;
					res_valid     = 1'b1;
				end
			end
			ST_WRITE: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = k_q;
				ram_req.wdata = w_q;
				res_valid     = 1'b1;
			end
			ST_PULL: begin
				res_valid = 1'b1;
				res.word  = ram_rdata;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			rp_q     <= '0;
			pref_q   <= '0;
			pinned_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (func)
							FUNC_START: begin
								count_q  <= '0;
								rp_q     <= '0;
								pinned_q <= 1'b0;
								pref_q   <= value;
							end
							FUNC_ADD: begin
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
									if (pin_hit) begin
										pinned_q <= 1'b1;
									end
									state_q <= (cnt_a == ADDR_W'(lo_new)) ? ST_WRITE : ST_SHIFT;
								end
							end
							FUNC_PULL: begin
								if (has_word) begin
									rp_q    <= rp_q + CNT_W'(1);
									state_q <= ST_PULL;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SHIFT: begin
					if (!shift) begin
						state_q <= ST_IDLE;
					end else if (!more) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_PULL: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// walk registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			if (acc && func == FUNC_ADD && !full) begin
				w_q     <= value;
				force_q <= pin_hit;
				lo_q    <= lo_new;
				k_q     <= cnt_a;
			end
		end else if (state_q == ST_SHIFT && shift) begin
			k_q <= k_dec;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/bfds_outq.sv -----
// Output register with one spare slot so input can be taken during a stall.
`default_nettype none
module bfds_outq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                res_valid,
	input  wire bfds_pkg::bfds_res_t res,
	output logic                     room,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [63:0]              word_out,
	output logic                     exhausted,
	output logic                     dropped
);
	import bfds_pkg::*;

	logic      out_valid_q;
	bfds_res_t out_q;
	logic      pend_q;
	bfds_res_t pend_data_q;
	logic      take;

	assign take      = !out_valid_q || out_ready;
	assign room      = !pend_q;
	assign out_valid = out_valid_q;
	assign word_out  = out_q.word;
	assign exhausted = out_q.exhausted;
	assign dropped   = out_q.dropped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (take) begin
			out_valid_q <= pend_q || res_valid;
			pend_q      <= 1'b0;
		end else if (res_valid) begin
			pend_q <= 1'b1;
		end
	end

	// a new result only arrives while the spare slot is empty
	always_ff @(posedge clk) begin
		if (take) begin
			if (pend_q) begin
				out_q <= pend_data_q;
			end else if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			pend_data_q <= res;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/best_first_descending_sorter_top.sv -----
// Descending word sorter with pinned front word: top level.
//
// Input beat (in_valid/in_ready): func and value. func start clears the list
// and records the preferred word (0 none); add inserts value in descending
// order, pinning the first match of a nonzero preferred word at the front;
// pull returns the next word. Every input beat yields exactly one output beat
// (out_valid/out_ready) carrying word_out, exhausted and dropped.
// Start, an unknown func, a dropped add and an exhausted pull hand their result
// straight to the output register; a pull first does one memory read; an add
// moves stored entries up one place to make room, since the insertion walk
// reads, compares and rewrites one entry of the single word memory per cycle.
// One item is in work at a time.
// Reset empties the list and clears the preferred word; the memory holds no
// valid data and needs no clearing pass.
// A finished beat waits in the output register; one further item is accepted
// and its beat held in a spare slot, after which in_ready stays low until the
// receiver takes a beat.
`default_nettype none
module best_first_descending_sorter_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [63:0] value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      word_out,
	output logic             exhausted,
	output logic             dropped
);
	import bfds_pkg::*;

	logic          room;
	logic          res_valid;
	bfds_res_t     res;
	bfds_ram_req_t ram_req;
	logic [WORD_W-1:0] ram_rdata;

	bfds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.value     (value),
		.room      (room),
		.res_valid (res_valid),
		.res       (res),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	bfds_ram #(
		.WIDTH (WORD_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	bfds_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.word_out  (word_out),
		.exhausted (exhausted),
		.dropped   (dropped)
	);

endmodule
`default_nettype wire

// ----- rtl/bfds_checker.sv -----
// Port-level checks for the sorter, bound to the top level.
`default_nettype none
module bfds_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  func,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] word_out,
	input wire logic        exhausted,
	input wire logic        dropped
);
	import bfds_pkg::*;

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(word_out)
			&& $stable(exhausted) && $stable(dropped))
		else $error("output beat changed under stall");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(exhausted && dropped))
		else $error("exhausted and dropped together");

	a_flag_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (exhausted || dropped) |-> word_out == '0)
		else $error("flagged beat carries a word");

	// a start beat accepted while the output is empty comes out in the next cycle with no flags set
	a_start_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == FUNC_START && !out_valid
			|=> out_valid && word_out == '0 && !exhausted && !dropped)
		else $error("start item result wrong");

endmodule

bind best_first_descending_sorter_top bfds_checker u_bfds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.func      (func),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.word_out  (word_out),
	.exhausted (exhausted),
	.dropped   (dropped)
);
`default_nettype wire
